FILE: src/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// Shared constants, types and transition tables of the connector status
// machine.
// ----------------------------------------------------------------------------
package csf_pkg;

    localparam int MAX_CONNECTORS = 15;
    localparam int NUM_ENTRIES    = MAX_CONNECTORS + 1;
    localparam int IDX_W          = $clog2(NUM_ENTRIES);

    localparam int MODE_W    = 2;
    localparam int CONN_W    = 8;
    localparam int EV_W      = 5;
    localparam int ERR_W     = 4;
    localparam int STAMP_W   = 32;
    localparam int STATE_W   = 4;
    localparam int COUNT_W   = 4;
    localparam int MAP_W     = 64;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP   = 2'd1;

    // item modes
    localparam logic [MODE_W-1:0] MODE_EVENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FAULT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ERROR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

    // connector states; status codes share 0..7
    localparam logic [STATE_W-1:0] S_AVAIL     = 4'd0;
    localparam logic [STATE_W-1:0] S_PREP      = 4'd1;
    localparam logic [STATE_W-1:0] S_CHRG      = 4'd2;
    localparam logic [STATE_W-1:0] S_SUSP_EVSE = 4'd3;
    localparam logic [STATE_W-1:0] S_SUSP_EV   = 4'd4;
    localparam logic [STATE_W-1:0] S_FINISH    = 4'd5;
    localparam logic [STATE_W-1:0] S_RESV      = 4'd6;
    localparam logic [STATE_W-1:0] S_UNAVAIL   = 4'd7;
    localparam logic [STATE_W-1:0] S_FAULTED   = 4'd8;
    localparam logic [STATE_W-1:0] S_INOP      = 4'd9;
    localparam logic [STATE_W-1:0] S_NONE      = 4'd15;

    localparam logic [STATE_W-1:0] STAT_NONE    = 4'd0;
    localparam logic [STATE_W-1:0] STAT_UNAVAIL = 4'd7;
    localparam logic [STATE_W-1:0] STAT_FAULTED = 4'd8;

    // events
    localparam logic [EV_W-1:0] EV_USAGE         = 5'd0;
    localparam logic [EV_W-1:0] EV_START         = 5'd1;
    localparam logic [EV_W-1:0] EV_PAUSE_EV      = 5'd2;
    localparam logic [EV_W-1:0] EV_PAUSE_EVSE    = 5'd3;
    localparam logic [EV_W-1:0] EV_RESERVE       = 5'd4;
    localparam logic [EV_W-1:0] EV_UNAVAIL       = 5'd5;
    localparam logic [EV_W-1:0] EV_INOP          = 5'd6;
    localparam logic [EV_W-1:0] EV_INOP_QUIET    = 5'd7;
    localparam logic [EV_W-1:0] EV_AVAIL         = 5'd8;
    localparam logic [EV_W-1:0] EV_STOP_USER     = 5'd9;
    localparam logic [EV_W-1:0] EV_RET_AVAIL     = 5'd10;
    localparam logic [EV_W-1:0] EV_RET_PREP      = 5'd11;
    localparam logic [EV_W-1:0] EV_RET_CHRG      = 5'd12;
    localparam logic [EV_W-1:0] EV_RET_SUSP_EV   = 5'd13;
    localparam logic [EV_W-1:0] EV_RET_SUSP_EVSE = 5'd14;
    localparam logic [EV_W-1:0] EV_RET_FINISH    = 5'd15;
    localparam logic [EV_W-1:0] EV_RET_RESV      = 5'd16;
    localparam logic [EV_W-1:0] EV_RET_UNAVAIL   = 5'd17;
    localparam logic [EV_W-1:0] EV_RET_INOP      = 5'd18;
    localparam logic [EV_W-1:0] EV_OPERATIVE     = 5'd19;
    localparam logic [EV_W-1:0] EV_OPER_QUIET    = 5'd20;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CONN_W-1:0]  connector;
        logic [EV_W-1:0]    event_code;
        logic [ERR_W-1:0]   err_code;
        logic [STAMP_W-1:0] time_stamp;
    } t_item;

    typedef struct packed {
        logic               faulted;
        logic [ERR_W-1:0]   error;
        logic [STATE_W-1:0] state;
    } t_entry;

    typedef struct packed {
        logic               accepted;
        logic               notify;
        logic [STATE_W-1:0] notify_status;
        logic [ERR_W-1:0]   notify_error;
        logic [CONN_W-1:0]  connector_echo;
        logic [STAMP_W-1:0] stamp_echo;
        logic [STATE_W-1:0] current_status;
        logic               config_fault;
    } t_result;

    function automatic logic [STATE_W-1:0] status_of(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] r;
        if (s <= S_UNAVAIL) begin
            r = s;
        end else if (s == S_INOP) begin
            r = STAT_UNAVAIL;
        end else begin
            r = STAT_FAULTED;
        end
        return r;
    endfunction

    // Full table for connectors 1 and up
    function automatic logic [STATE_W-1:0] main_next(input logic [STATE_W-1:0] s,
                                                     input logic [EV_W-1:0]    ev);
        logic [STATE_W-1:0] n;
        logic               op;
        logic               flt;
        n   = S_NONE;
        op  = (s <= S_UNAVAIL);
        flt = (s == S_FAULTED);
        unique case (ev)
            EV_USAGE: begin
                if (s == S_AVAIL || s == S_FINISH || s == S_RESV || s == S_UNAVAIL)
                    n = S_PREP;
            end
            EV_START: begin
                if (s == S_AVAIL || s == S_PREP || s == S_SUSP_EVSE || s == S_SUSP_EV
                    || s == S_UNAVAIL)
                    n = S_CHRG;
            end
            EV_PAUSE_EV: begin
                if (s == S_AVAIL || s == S_PREP || s == S_CHRG || s == S_SUSP_EVSE
                    || s == S_UNAVAIL)
                    n = S_SUSP_EV;
            end
            EV_PAUSE_EVSE: begin
                if (s == S_AVAIL || s == S_PREP || s == S_CHRG || s == S_SUSP_EV
                    || s == S_UNAVAIL)
                    n = S_SUSP_EVSE;
            end
            EV_RESERVE: begin
                if (s == S_AVAIL) n = S_RESV;
            end
            EV_UNAVAIL: begin
                if (s == S_AVAIL || s == S_CHRG || s == S_SUSP_EVSE || s == S_SUSP_EV
                    || s == S_FINISH || s == S_RESV)
                    n = S_UNAVAIL;
            end
            EV_INOP, EV_INOP_QUIET: begin
                if (op) n = S_INOP;
            end
            EV_AVAIL: begin
                if (op && s != S_AVAIL) n = S_AVAIL;
            end
            EV_STOP_USER: begin
                if (s == S_PREP || s == S_CHRG || s == S_SUSP_EVSE || s == S_SUSP_EV)
                    n = S_FINISH;
            end
            EV_RET_AVAIL:     if (flt) n = S_AVAIL;
            EV_RET_PREP:      if (flt) n = S_PREP;
            EV_RET_CHRG:      if (flt) n = S_CHRG;
            EV_RET_SUSP_EV:   if (flt) n = S_SUSP_EV;
            EV_RET_SUSP_EVSE: if (flt) n = S_SUSP_EVSE;
            EV_RET_FINISH:    if (flt) n = S_FINISH;
            EV_RET_RESV:      if (flt) n = S_RESV;
            EV_RET_UNAVAIL:   if (flt) n = S_UNAVAIL;
            EV_RET_INOP:      if (flt) n = S_INOP;
            EV_OPERATIVE, EV_OPER_QUIET: begin
                if (s == S_INOP) n = S_AVAIL;
            end
            default: n = S_NONE;
        endcase
        return n;
    endfunction

    // Reduced table for the station as a whole
    function automatic logic [STATE_W-1:0] zero_next(input logic [STATE_W-1:0] s,
                                                     input logic [EV_W-1:0]    ev);
        logic [STATE_W-1:0] n;
        n = S_NONE;
        unique case (ev)
            EV_UNAVAIL:     if (s == S_AVAIL)   n = S_UNAVAIL;
            EV_AVAIL:       if (s == S_UNAVAIL) n = S_AVAIL;
            EV_RET_AVAIL:   if (s == S_FAULTED) n = S_AVAIL;
            EV_RET_UNAVAIL: if (s == S_FAULTED) n = S_UNAVAIL;
            EV_RET_INOP:    if (s == S_FAULTED) n = S_INOP;
            EV_OPERATIVE, EV_OPER_QUIET: begin
                if (s == S_INOP) n = S_AVAIL;
            end
            default: n = S_NONE;
        endcase
        return n;
    endfunction

endpackage

FILE: src/csf_if.sv
// ----------------------------------------------------------------------------
// csf_if
// Valid/ready channels of the connector status machine: event items in,
// result items out, register writes in.
// ----------------------------------------------------------------------------
interface csf_evt_if;
    logic                         valid;
    logic                         ready;
    logic [csf_pkg::MODE_W-1:0]   mode;
    logic [csf_pkg::CONN_W-1:0]   connector;
    logic [csf_pkg::EV_W-1:0]     event_code;
    logic [csf_pkg::ERR_W-1:0]    err_code;
    logic [csf_pkg::STAMP_W-1:0]  time_stamp;

    modport source (output valid, mode, connector, event_code, err_code, time_stamp,
                    input ready);
    modport sink   (input valid, mode, connector, event_code, err_code, time_stamp,
                    output ready);
endinterface

interface csf_res_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic                         notify;
    logic [csf_pkg::STATE_W-1:0]  notify_status;
    logic [csf_pkg::ERR_W-1:0]    notify_error;
    logic [csf_pkg::CONN_W-1:0]   connector_echo;
    logic [csf_pkg::STAMP_W-1:0]  stamp_echo;
    logic [csf_pkg::STATE_W-1:0]  current_status;
    logic                         config_fault;

    modport source (output valid, accepted, notify, notify_status, notify_error,
                           connector_echo, stamp_echo, current_status, config_fault,
                    input ready);
    modport sink   (input valid, accepted, notify, notify_status, notify_error,
                          connector_echo, stamp_echo, current_status, config_fault,
                    output ready);
endinterface

interface csf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [csf_pkg::CFG_IDX_W-1:0] index;
    logic [csf_pkg::MAP_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/connector_status_fsm.sv
// ----------------------------------------------------------------------------
// connector_status_fsm
// Charging-station connector status machine: one state, error code and
// fault flag per connector, kept in a small state memory.
// ----------------------------------------------------------------------------
// Accepting an item issues the read of the connector's entry from the
// state memory; in the update state the entry is updated, written back and
// the result register is loaded. One item is in work at a time, so a new
// item is not taken until the last one has been updated; the result
// register holds a finished item while the next is accepted, and the update
// waits only if that register is still full. After reset, and after a write
// to either register, the memory is loaded from the initial state map in a
// sweep over all 16 entries (one entry a cycle) with error codes and fault flags
// cleared; no item is taken during the sweep, register writes are always
// taken. Connector 0 follows the reduced station table, connectors
// 1..connector_count the full one; higher numbers are ignored and report
// unavailable. An invalid station entry in the map blocks every item with
// config_fault set.
module connector_status_fsm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csf_evt_if.sink       i_evt,
    csf_res_if.source     o_res,
    csf_cfg_if.sink       i_cfg
);
    import csf_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic               r_state;
    logic               n_state;
    logic [COUNT_W-1:0] r_count;
    logic [MAP_W-1:0]   r_map;
    t_item              r_item;
    t_result            r_out;
    logic               r_out_valid;

    logic               cfg_wr;
    logic               restart;
    logic               map_invalid;
    logic [COUNT_W-1:0] limit;
    logic               evt_acc;
    logic               exec_go;
    logic               st_busy;
    t_entry             rd_entry;
    t_entry             wr_entry;
    logic               nx_wr_en;
    t_result            nx_result;

    // ---- register writes -----------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    // only the two real registers trigger a reload
    assign restart     = cfg_wr && (i_cfg.index == REG_COUNT || i_cfg.index == REG_MAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(1);
            r_map   <= '0;
        end else if (cfg_wr) begin
            if (i_cfg.index == REG_COUNT) r_count <= i_cfg.data[COUNT_W-1:0];
            if (i_cfg.index == REG_MAP)   r_map   <= i_cfg.data;
        end
    end

    // station entry must start in a state it can actually leave
    assign map_invalid = !(r_map[STATE_W-1:0] == S_AVAIL   ||
                           r_map[STATE_W-1:0] == S_UNAVAIL ||
                           r_map[STATE_W-1:0] == S_FAULTED ||
                           r_map[STATE_W-1:0] == S_INOP);
    assign limit = (r_count < COUNT_W'(MAX_CONNECTORS)) ? r_count
                                                        : COUNT_W'(MAX_CONNECTORS);

    // ---- item sequencing -------------------------------------------------
    assign i_evt.ready = (r_state == ST_IDLE) && !st_busy;
    assign evt_acc     = i_evt.valid && i_evt.ready;
    assign exec_go     = (r_state == ST_EXEC) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (evt_acc) n_state = ST_EXEC;
            ST_EXEC: if (exec_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go)          r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt_acc) begin
            r_item.mode       <= i_evt.mode;
            r_item.connector  <= i_evt.connector;
            r_item.event_code <= i_evt.event_code;
            r_item.err_code   <= i_evt.err_code;
            r_item.time_stamp <= i_evt.time_stamp;
        end
        if (exec_go) r_out <= nx_result;
    end

    // ---- state memory and update -----------------------------------------
    csf_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_map     (r_map),
        .i_rd_en   (evt_acc),
        .i_rd_addr (i_evt.connector[IDX_W-1:0]),
        .i_wr_en   (exec_go && nx_wr_en),
        .i_wr_addr (r_item.connector[IDX_W-1:0]),
        .i_wr_data (wr_entry),
        .o_rd_data (rd_entry),
        .o_busy    (st_busy)
    );

    csf_next u_next (
        .i_item        (r_item),
        .i_entry       (rd_entry),
        .i_limit       (limit),
        .i_map_invalid (map_invalid),
        .o_result      (nx_result),
        .o_wr_en       (nx_wr_en),
        .o_entry       (wr_entry)
    );

    // ---- result port -----------------------------------------------------
    assign o_res.valid          = r_out_valid;
    assign o_res.accepted       = r_out.accepted;
    assign o_res.notify         = r_out.notify;
    assign o_res.notify_status  = r_out.notify_status;
    assign o_res.notify_error   = r_out.notify_error;
    assign o_res.connector_echo = r_out.connector_echo;
    assign o_res.stamp_echo     = r_out.stamp_echo;
    assign o_res.current_status = r_out.current_status;
    assign o_res.config_fault   = r_out.config_fault;

`ifndef SYNTHESIS
    a_no_item_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_busy |-> !i_evt.ready)
        else $error("item taken during state load sweep");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt_acc |=> (r_state == ST_EXEC))
        else $error("accepted item not moved to update");

    a_notify_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.notify) |-> o_res.accepted)
        else $error("notification without accepted change");

    a_fault_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.config_fault) |-> (!o_res.accepted && !o_res.notify))
        else $error("item acted on despite invalid map");

    a_exec_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go |=> r_out_valid)
        else $error("update did not load the result register");
`endif

endmodule

FILE: src/csf_store.sv
// ----------------------------------------------------------------------------
// csf_store
// Per-connector state memory with registered read and a load
// sweep that writes every entry from the initial state map.
// ----------------------------------------------------------------------------
module csf_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  logic [csf_pkg::MAP_W-1:0]   i_map,
    input  logic                        i_rd_en,
    input  logic [csf_pkg::IDX_W-1:0]   i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [csf_pkg::IDX_W-1:0]   i_wr_addr,
    input  csf_pkg::t_entry             i_wr_data,
    output csf_pkg::t_entry             o_rd_data,
    output logic                        o_busy
);
    import csf_pkg::*;

    t_entry             mem [NUM_ENTRIES];
    t_entry             r_rd_data;
    t_entry             sweep_data;
    logic               r_busy;
    logic [IDX_W-1:0]   r_cnt;

    always_comb begin
        sweep_data         = '0;
        sweep_data.state   = i_map[r_cnt * STATE_W +: STATE_W];
    end

    // sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == IDX_W'(NUM_ENTRIES - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_cnt] <= sweep_data;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

FILE: src/csf_next.sv
// ----------------------------------------------------------------------------
// csf_next
// Update logic: from one item and its connector's stored entry, forms the
// new entry and the result item.
// ----------------------------------------------------------------------------
module csf_next (
    input  csf_pkg::t_item                  i_item,
    input  csf_pkg::t_entry                 i_entry,
    input  logic [csf_pkg::COUNT_W-1:0]     i_limit,
    input  logic                            i_map_invalid,
    output csf_pkg::t_result                o_result,
    output logic                            o_wr_en,
    output csf_pkg::t_entry                 o_entry
);
    import csf_pkg::*;

    logic [STATE_W-1:0] nxt;
    logic               valid_conn;
    logic               taken;
    logic               quiet;
    t_entry             upd;

    assign valid_conn = (i_item.connector <= CONN_W'(i_limit));
    assign nxt = (i_item.connector == '0) ? zero_next(i_entry.state, i_item.event_code)
                                          : main_next(i_entry.state, i_item.event_code);
    assign quiet = (i_item.event_code == EV_INOP_QUIET) ||
                   (i_item.event_code == EV_OPER_QUIET);

    always_comb begin
        upd      = i_entry;
        taken    = 1'b0;
        o_result = '0;
        o_result.connector_echo = i_item.connector;
        o_result.stamp_echo     = i_item.time_stamp;
        o_result.current_status = STAT_UNAVAIL;
        o_result.config_fault   = i_map_invalid;

        if (!i_map_invalid && valid_conn) begin
            unique case (i_item.mode)
                MODE_EVENT: begin
                    if (nxt != S_NONE) begin
                        taken     = 1'b1;
                        upd.state = nxt;
                        if (!i_entry.faulted && !quiet) begin
                            o_result.notify        = 1'b1;
                            o_result.notify_status = status_of(nxt);
                            o_result.notify_error  = i_entry.error;
                        end
                    end
                end
                MODE_FAULT, MODE_ERROR: begin
                    if (i_item.err_code != i_entry.error) begin
                        taken     = 1'b1;
                        upd.error = i_item.err_code;
                        if (i_item.mode == MODE_FAULT)
                            upd.faulted = (i_item.err_code != '0);
                        o_result.notify        = 1'b1;
                        o_result.notify_status = upd.faulted ? STAT_FAULTED
                                                             : status_of(upd.state);
                        o_result.notify_error  = i_item.err_code;
                    end
                end
                MODE_QUERY: taken = 1'b0;
                default:    taken = 1'b0;
            endcase
            o_result.accepted       = taken;
            o_result.current_status = upd.faulted ? STAT_FAULTED : status_of(upd.state);
        end
    end

    assign o_wr_en = taken;
    assign o_entry = upd;

endmodule
